[src/nrgt_pkg.sv]
// Shared types and constants for the nearest-record tuning table.
// Used by the channel interfaces and the top-level unit; no dependencies.
package nrgt_pkg;

	localparam int KeyW   = 16;
	localparam int BatchW = 16;
	localparam int KindW  = 2;
	localparam int SqW    = 2 * KeyW;
	localparam int DistW  = SqW + 2;
	localparam int EntryW = 3 * KeyW + 1 + BatchW;

	localparam logic [KindW-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KindW-1:0] KIND_LOAD  = 2'd1;
	localparam logic [KindW-1:0] KIND_QUERY = 2'd2;

	typedef struct packed {
		logic [KindW-1:0]  kind;
		logic [KeyW-1:0]   key_m;
		logic [KeyW-1:0]   key_n;
		logic [KeyW-1:0]   key_k;
		logic              rec_flag;
		logic [BatchW-1:0] rec_batch;
	} req_item_t;

	typedef struct packed {
		logic              found;
		logic              use_flag;
		logic [BatchW-1:0] batch;
	} rsp_item_t;

endpackage

[src/nrgt_if.sv]
// Valid/ready channel interfaces for request and response transfers.
// Depends on nrgt_pkg for the payload types.
interface nrgt_req_if;
	import nrgt_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nrgt_rsp_if;
	import nrgt_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/nearest_record_gemm_tuning_unit.sv]
// Nearest-record tuning table: record memory, scan pipeline and result register.
// Depends on nrgt_pkg and the channel interfaces in nrgt_if.sv.
// After a clear or load transfer the unit stays idle and is ready again next cycle.
// A query scans the records through the read, squaring and distance stages into the best
// register; the single memory read port scans one record a cycle, and a result not yet
// taken holds the unit. Reset empties the table and the output register, not the memory.
module nearest_record_gemm_tuning_unit #(
	parameter int TABLE_DEPTH = 256
) (
	input logic         clk,
	input logic         arst_n,
	nrgt_req_if.sink    req,
	nrgt_rsp_if.source  rsp
);
	import nrgt_pkg::*;

	localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CntW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	state_t            state_q;
	logic [CntW-1:0]   count_q;
	logic [CntW-1:0]   issue_cnt_q;
	logic [KeyW-1:0]   qm_q, qn_q, qk_q;
	logic              out_valid_q;
	rsp_item_t         out_data_q;

	logic [EntryW-1:0] mem [TABLE_DEPTH];
	logic [EntryW-1:0] rd_data_q;
	logic              wr_en;
	logic [IdxW-1:0]   rd_addr;

	logic              v_s1_q, v_s2_q, v_s3_q;
	logic [SqW-1:0]    sq_m_s2, sq_n_s2, sq_k_s2;
	logic              flag_s2, flag_s3;
	logic [BatchW-1:0] batch_s2, batch_s3;
	logic [DistW-1:0]  dist_s3;

	logic              best_valid_q;
	logic [DistW-1:0]  best_dist_q;
	logic              best_flag_q;
	logic [BatchW-1:0] best_batch_q;

	logic              req_xfer, start_query, issue, scan_done, out_free;
	logic [KeyW-1:0]   rm, rn, rk, dm, dn, dk;
	logic              rflag;
	logic [BatchW-1:0] rbatch;

	assign req.ready   = (state_q == ST_IDLE);
	assign req_xfer    = req.valid && req.ready;
	assign start_query = req_xfer && (req.data.kind == KIND_QUERY);
	assign wr_en       = req_xfer && (req.data.kind == KIND_LOAD)
	                     && (count_q < CntW'(TABLE_DEPTH));
	assign issue       = (state_q == ST_SCAN) && (issue_cnt_q < count_q);
	assign rd_addr     = issue_cnt_q[IdxW-1:0];
	assign scan_done   = (issue_cnt_q == count_q) && !v_s1_q && !v_s2_q && !v_s3_q;
	assign out_free    = !out_valid_q || rsp.ready;
	assign rsp.valid   = out_valid_q;
	assign rsp.data    = out_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IdxW-1:0]] <= {req.data.key_m, req.data.key_n, req.data.key_k,
			                           req.data.rec_flag, req.data.rec_batch};
		end
		rd_data_q <= mem[rd_addr];
	end

	assign {rm, rn, rk, rflag, rbatch} = rd_data_q;
	assign dm = (rm >= qm_q) ? (rm - qm_q) : (qm_q - rm);
	assign dn = (rn >= qn_q) ? (rn - qn_q) : (qn_q - rn);
	assign dk = (rk >= qk_q) ? (rk - qk_q) : (qk_q - rk);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q       <= 1'b0;
			v_s2_q       <= 1'b0;
			v_s3_q       <= 1'b0;
			best_valid_q <= 1'b0;
		end else begin
			v_s1_q <= issue;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			if (start_query) begin
				best_valid_q <= 1'b0;
			end else if (v_s3_q && (!best_valid_q || dist_s3 < best_dist_q)) begin
				best_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_m_s2  <= SqW'(dm) * SqW'(dm);
		sq_n_s2  <= SqW'(dn) * SqW'(dn);
		sq_k_s2  <= SqW'(dk) * SqW'(dk);
		flag_s2  <= rflag;
		batch_s2 <= (rn == rbatch) ? qn_q : rbatch;
		dist_s3  <= DistW'(sq_m_s2) + DistW'(sq_n_s2) + DistW'(sq_k_s2);
		flag_s3  <= flag_s2;
		batch_s3 <= batch_s2;
		if (v_s3_q && (!best_valid_q || dist_s3 < best_dist_q)) begin
			best_dist_q  <= dist_s3;
			best_flag_q  <= flag_s3;
			best_batch_q <= batch_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issue_cnt_q <= '0;
			qm_q        <= '0;
			qn_q        <= '0;
			qk_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						case (req.data.kind)
							KIND_CLEAR: count_q <= '0;
							KIND_LOAD: begin
								if (wr_en) begin
									count_q <= count_q + 1'b1;
								end
							end
							KIND_QUERY: begin
								qm_q        <= req.data.key_m;
								qn_q        <= req.data.key_n;
								qk_q        <= req.data.key_k;
								issue_cnt_q <= '0;
								state_q     <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_data_q.found    <= best_valid_q;
						out_data_q.use_flag <= best_valid_q && best_flag_q;
						out_data_q.batch    <= best_valid_q ? best_batch_q : qn_q;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(TABLE_DEPTH))
		else $error("record count exceeds table depth");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_cnt_q <= count_q || state_q != ST_SCAN)
		else $error("scan read past the last stored record");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1_q || v_s2_q || v_s3_q) |-> state_q == ST_SCAN)
		else $error("scan pipeline active outside a query");

	a_load_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> count_q == $past(count_q) + 1'b1)
		else $error("accepted load did not append a record");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!v_s1_q && !v_s2_q && !v_s3_q && issue_cnt_q == count_q))
		else $error("query finished before the scan drained");

endmodule

[tb/sv/tb_nearest_record_gemm_tuning_unit.sv]
// Self-checking testbench for the nearest-record tuning table: directed rows, then random
// clear/load/query sequences; each answer is checked against its script row or a predictor.
// Depends on nrgt_pkg, the channel interfaces in nrgt_if.sv and the top-level unit.
module tb_nearest_record_gemm_tuning_unit;
	import nrgt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 256;
	localparam int ITEM_TARGET = 1700;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		req_item_t item;
		logic      typed;
		rsp_item_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;

	nrgt_req_if req ();
	nrgt_rsp_if rsp ();

	nearest_record_gemm_tuning_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	logic [KeyW-1:0]   rec_key [TABLE_DEPTH][3];
	logic              rec_flag_tab [TABLE_DEPTH];
	logic [BatchW-1:0] rec_batch_tab [TABLE_DEPTH];
	int                rec_count = 0;

	rsp_item_t awaited_results [$];
	int        mismatches = 0;
	int        cycle_count = 0;
	int        table_transfers = 0;
	int        snd_idle_pct = 35;
	int        rcv_idle_pct = 57;

	script_row_t script [22];

	function automatic longint unsigned sq_gap(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
		longint unsigned d;
		d = (a >= b) ? a - b : b - a;
		return d * d;
	endfunction

	function automatic rsp_item_t nearest_record(req_item_t q);
		longint unsigned best_dist;
		longint unsigned gap_sum;
		int best;
		rsp_item_t r;
		r.found = 1'b0;
		r.use_flag = 1'b0;
		r.batch = q.key_n;
		if (rec_count > 0) begin
			best = 0;
			best_dist = '1;
			for (int i = 0; i < rec_count; i++) begin
				gap_sum = sq_gap(rec_key[i][0], q.key_m) + sq_gap(rec_key[i][1], q.key_n)
					+ sq_gap(rec_key[i][2], q.key_k);
				if (gap_sum < best_dist) begin
					best_dist = gap_sum;
					best = i;
				end
			end
			r.found = 1'b1;
			r.use_flag = rec_flag_tab[best];
			r.batch = (rec_key[best][1] == rec_batch_tab[best]) ? q.key_n : rec_batch_tab[best];
		end
		return r;
	endfunction

	function automatic void track_transfer(req_item_t it, logic typed, rsp_item_t want);
		case (it.kind)
			KIND_CLEAR: begin
				rec_count = 0;
			end
			KIND_LOAD: begin
				if (rec_count < TABLE_DEPTH) begin
					rec_key[rec_count][0] = it.key_m;
					rec_key[rec_count][1] = it.key_n;
					rec_key[rec_count][2] = it.key_k;
					rec_flag_tab[rec_count] = it.rec_flag;
					rec_batch_tab[rec_count] = it.rec_batch;
					rec_count++;
				end
			end
			KIND_QUERY: begin
				awaited_results.push_back(typed ? want : nearest_record(it));
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send_item(req_item_t it, logic typed = 1'b0, rsp_item_t want = '0);
		int gap;
		gap = 0;
		while (gap < 12 && $urandom_range(0, 99) < snd_idle_pct)
			gap++;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= it;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		track_transfer(it, typed, want);
		if (it.kind != KIND_UNUSED)
			table_transfers++;
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KeyW-1:0] pick_key(int axis);
		int sel;
		int idx;
		sel = $urandom_range(0, 4);
		if (sel >= 3 && rec_count > 0) begin
			idx = $urandom_range(0, rec_count - 1);
			return rec_key[idx][axis] + KeyW'($urandom_range(0, 6)) - KeyW'(3);
		end
		case (sel)
			0: return KeyW'($urandom);
			1: return KeyW'($urandom_range(0, 31));
			default: return KeyW'(16'hFFFF - $urandom_range(0, 31));
		endcase
	endfunction

	function automatic req_item_t random_item(logic [KindW-1:0] kind);
		req_item_t it;
		int src;
		it.kind = kind;
		it.key_m = pick_key(0);
		it.key_n = pick_key(1);
		it.key_k = pick_key(2);
		it.rec_flag = 1'($urandom);
		it.rec_batch = BatchW'($urandom);
		if (kind == KIND_LOAD) begin
			if (rec_count > 0 && $urandom_range(0, 99) < 15) begin
				src = $urandom_range(0, rec_count - 1);
				it.key_m = rec_key[src][0];
				it.key_n = rec_key[src][1];
				it.key_k = rec_key[src][2];
			end
			if ($urandom_range(0, 99) < 25)
				it.rec_batch = it.key_n;
		end
		return it;
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result found=%0b use_flag=%0b batch=%h", $time,
					rsp.data.found, rsp.data.use_flag, rsp.data.batch);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (rsp.data.found !== want.found) begin
					$display("%0t: found expected %0b actual %0b", $time, want.found,
						rsp.data.found);
					mismatches++;
				end
				if (rsp.data.use_flag !== want.use_flag) begin
					$display("%0t: use_flag expected %0b actual %0b", $time, want.use_flag,
						rsp.data.use_flag);
					mismatches++;
				end
				if (rsp.data.batch !== want.batch) begin
					$display("%0t: batch expected %h actual %h", $time, want.batch,
						rsp.data.batch);
					mismatches++;
				end
			end
		end
		rsp.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	initial begin
		int nops;
		int pick;
		int fills;
		int phase;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		fills = 0;
		phase = 0;

		// The table starts empty, so the first rows expect the query n back.
		script = '{
			'{'{KIND_QUERY, 16'h0000, 16'h1234, 16'h0000, 1'b0, 16'h0000}, 1'b1,
				'{1'b0, 1'b0, 16'h1234}},
			'{'{KIND_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b1,
				'{1'b0, 1'b0, 16'hFFFF}},
			'{'{KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b0, '0},
			'{'{KIND_LOAD, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF}, 1'b0, '0},
			'{'{KIND_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000}, 1'b1,
				'{1'b1, 1'b1, 16'hFFFF}},
			'{'{KIND_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF}, 1'b0, '0},
			'{'{KIND_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000}, 1'b1,
				'{1'b1, 1'b1, 16'hFFFF}},
			'{'{KIND_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000}, 1'b1,
				'{1'b1, 1'b0, 16'hFFFF}},
			'{'{KIND_QUERY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000}, 1'b0, '0},
			'{'{KIND_QUERY, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0000}, 1'b0, '0},
			'{'{KIND_LOAD, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0005}, 1'b0, '0},
			'{'{KIND_QUERY, 16'h0000, 16'h0000, 16'h0001, 1'b0, 16'h0000}, 1'b0, '0},
			'{'{KIND_LOAD, 16'h0005, 16'h0064, 16'h0007, 1'b1, 16'h0064}, 1'b0, '0},
			'{'{KIND_QUERY, 16'h0005, 16'h004D, 16'h0007, 1'b0, 16'h0000}, 1'b0, '0},
			'{'{KIND_UNUSED, 16'h0005, 16'h004D, 16'h0007, 1'b0, 16'h0000}, 1'b0, '0},
			'{'{KIND_QUERY, 16'h0005, 16'h0064, 16'h0007, 1'b1, 16'h1111}, 1'b0, '0},
			'{'{KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000}, 1'b0, '0},
			'{'{KIND_QUERY, 16'h0001, 16'h0002, 16'h0003, 1'b0, 16'h0000}, 1'b1,
				'{1'b0, 1'b0, 16'h0002}},
			'{'{KIND_LOAD, 16'h00FF, 16'hFF00, 16'h5555, 1'b0, 16'hAAAA}, 1'b0, '0},
			'{'{KIND_QUERY, 16'hAAAA, 16'h5555, 16'h00FF, 1'b0, 16'h0000}, 1'b0, '0},
			'{'{KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b0, '0},
			'{'{KIND_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF}, 1'b1,
				'{1'b0, 1'b0, 16'h0000}}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_item(script[i].item, script[i].typed, script[i].want);

		table_transfers = 0;
		while (table_transfers < ITEM_TARGET) begin
			if (phase == 0 && table_transfers >= ITEM_TARGET / 3) begin
				phase = 1;
				drain_results();
				snd_idle_pct = 57;
				rcv_idle_pct = 35;
			end else if (phase == 1 && table_transfers >= 2 * ITEM_TARGET / 3) begin
				phase = 2;
				drain_results();
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end

			if (fills < 2 && table_transfers >= 300 + fills * 700) begin
				// Fill the table past its depth so the last loads are dropped.
				send_item(random_item(KIND_CLEAR));
				repeat (TABLE_DEPTH + $urandom_range(1, 4))
					send_item(random_item(KIND_LOAD));
				repeat (3)
					send_item(random_item(KIND_QUERY));
				fills++;
			end else begin
				if ($urandom_range(0, 99) < 60)
					send_item(random_item(KIND_CLEAR));
				nops = $urandom_range(2, 14);
				repeat (nops) begin
					pick = $urandom_range(0, 99);
					if (pick < 50)
						send_item(random_item(KIND_LOAD));
					else if (pick < 90)
						send_item(random_item(KIND_QUERY));
					else if (pick < 95)
						send_item(random_item(KIND_UNUSED));
					else
						send_item(random_item(KIND_CLEAR));
				end
			end
		end

		drain_results();
		repeat (TABLE_DEPTH + 16) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
src/nrgt_pkg.sv
src/nrgt_if.sv
src/nearest_record_gemm_tuning_unit.sv
tb/sv/tb_nearest_record_gemm_tuning_unit.sv
